// ----- rtl/clsort_pkg.sv -----
// Shared types and constants of the cell-list counting sort.
// Used by clsort_mul, clsort_core and cell_list_counting_sort.
package clsort_pkg;

    localparam int MAX_PARTICLES = 4096;
    localparam int MAX_CELLS     = 4096;
    localparam int ID_W          = 12;
    localparam int CELL_W        = 12;
    localparam int CNT_W         = 13;
    localparam int AXIS_W        = 13;
    localparam int SCALE_W       = 20;
    localparam int COORD_W       = 16;
    localparam int MUL_A_W       = 27;
    localparam int MUL_B_W       = 20;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int OP_W          = 3;
    localparam int CFG_IDX_W     = 3;

    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_BUILD     = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_SLOT = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_CELL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd5;

    typedef struct packed {
        logic [AXIS_W-1:0]  cells_x;
        logic [AXIS_W-1:0]  cells_y;
        logic [AXIS_W-1:0]  cells_z;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
        logic [SCALE_W-1:0] scale_z;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [ID_W-1:0]    particle_id;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [ID_W-1:0]    slot;
        logic [CELL_W-1:0]  cell_req;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]   sorted_id;
        logic [CELL_W-1:0] cell_of_item;
        logic [CNT_W-1:0]  cell_start;
        logic [CNT_W-1:0]  cell_count;
        logic [CNT_W-1:0]  total_count;
        logic              out_of_range;
    } res_t;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_G0, ST_G1, ST_G2,
        ST_IX, ST_IY, ST_IZ, ST_IL0, ST_IL1, ST_ICNT,
        ST_CLR, ST_BRD, ST_BWR, ST_PRD, ST_PCI, ST_PSC,
        ST_RSLOT, ST_RCELL, ST_DONE
    } state_t;

endpackage

// ----- rtl/clsort_mul.sv -----
// Shared multiplier of the sequencer, product registered.
// Depends on clsort_pkg.
module clsort_mul (
    input  logic                            clk,
    input  logic [clsort_pkg::MUL_A_W-1:0]  a,
    input  logic [clsort_pkg::MUL_B_W-1:0]  b,
    output logic [clsort_pkg::PROD_W-1:0]   prod
);
    import clsort_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/clsort_core.sv -----
// Sequencer, cell memories and counters of the counting sort.
// Depends on clsort_pkg and clsort_mul.
module clsort_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clsort_pkg::cfg_t     cfg,
    input  logic                 req_valid,
    input  clsort_pkg::req_t     req,
    output logic                 req_ready,
    output logic                 res_valid,
    output clsort_pkg::res_t     res,
    input  logic                 res_ready
);
    import clsort_pkg::*;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    res_t                res_reg, res_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [CNT_W-1:0]    active_reg, active_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                big_reg, big_next;
    logic                flag_reg, flag_next;
    logic [AXIS_W-1:0]   cx_reg, cx_next;
    logic [AXIS_W-1:0]   cy_reg, cy_next;
    logic [AXIS_W-1:0]   cz_reg, cz_next;
    logic [CELL_W-1:0]   lin_reg, lin_next;
    logic [CELL_W-1:0]   ci_reg, ci_next;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   prod;

    logic [AXIS_W-1:0]   nx, ny, nz;
    logic [39:0]         grid;
    logic [AXIS_W:0]     sat;
    logic [MUL_A_W-1:0]  tsum;
    logic [40:0]         lin_full;
    logic [CNT_W:0]      at;

    logic [CELL_W-1:0] pc_mem [MAX_PARTICLES];
    logic [CNT_W-1:0]  cc_mem [MAX_CELLS];
    logic [CNT_W-1:0]  st_mem [MAX_CELLS];
    logic [ID_W-1:0]   so_mem [MAX_PARTICLES];

    logic              pc_we, cc_we, st_we, so_we;
    logic [ID_W-1:0]   pc_waddr, pc_raddr, so_waddr, so_raddr;
    logic [CELL_W-1:0] cc_waddr, cc_raddr, st_waddr, st_raddr;
    logic [CELL_W-1:0] pc_wdata, pc_rd;
    logic [CNT_W-1:0]  cc_wdata, cc_rd, st_wdata, st_rd;
    logic [ID_W-1:0]   so_wdata, so_rd;

    function automatic logic [AXIS_W:0] axis_sat(input logic [19:0] c,
                                                 input logic [AXIS_W-1:0] n);
        logic [AXIS_W:0] r;
        begin
            r = {1'b0, c[AXIS_W-1:0]};
            if (c == {7'b0, n})
            begin
                r = {1'b0, n - 1'b1};
            end
            else if (c > {7'b0, n})
            begin
                r = {1'b1, n - 1'b1};
            end
            return r;
        end
    endfunction

    clsort_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign nx = (cfg.cells_x == '0) ? AXIS_W'(1) : cfg.cells_x;
    assign ny = (cfg.cells_y == '0) ? AXIS_W'(1) : cfg.cells_y;
    assign nz = (cfg.cells_z == '0) ? AXIS_W'(1) : cfg.cells_z;
    assign grid     = prod[39:0];
    assign sat      = axis_sat(prod[35:16], (state_reg == ST_IX) ? nx :
                               (state_reg == ST_IY) ? ny : nz);
    assign tsum     = prod[MUL_A_W-1:0] + MUL_A_W'(cy_reg);
    assign lin_full = prod[40:0] + 41'(cz_reg);
    assign at       = {1'b0, st_rd} + {1'b0, cc_rd};

    always_ff @(posedge clk)
    begin
        if (pc_we)
        begin
            pc_mem[pc_waddr] <= pc_wdata;
        end
        pc_rd <= pc_mem[pc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cc_we)
        begin
            cc_mem[cc_waddr] <= cc_wdata;
        end
        cc_rd <= cc_mem[cc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        st_rd <= st_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (so_we)
        begin
            so_mem[so_waddr] <= so_wdata;
        end
        so_rd <= so_mem[so_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        res_reg    <= res_next;
        run_reg    <= run_next;
        active_reg <= active_next;
        big_reg    <= big_next;
        flag_reg   <= flag_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        lin_reg    <= lin_next;
        ci_reg     <= ci_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        res_next    = res_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        active_next = active_reg;
        total_next  = total_reg;
        big_next    = big_reg;
        flag_next   = flag_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        cz_next     = cz_reg;
        lin_next    = lin_reg;
        ci_next     = ci_reg;
        mul_a       = '0;
        mul_b       = '0;
        pc_we = 1'b0; pc_waddr = '0; pc_wdata = '0; pc_raddr = '0;
        cc_we = 1'b0; cc_waddr = '0; cc_wdata = '0; cc_raddr = '0;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
        so_we = 1'b0; so_waddr = '0; so_wdata = '0; so_raddr = '0;
        req_ready = 1'b0;
        res_valid = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLR:
            begin
                cc_we    = 1'b1;
                cc_waddr = cnt_reg[CELL_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[CELL_W-1:0] == CELL_W'(MAX_CELLS - 1))
                begin
                    cnt_next   = '0;
                    total_next = '0;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    res_next   = '0;
                    flag_next  = 1'b0;
                    state_next = ST_G0;
                end
            end
            ST_G0:
            begin
                mul_a      = MUL_A_W'(nx);
                mul_b      = MUL_B_W'(ny);
                state_next = ST_G1;
            end
            ST_G1:
            begin
                mul_a      = prod[MUL_A_W-1:0];
                mul_b      = MUL_B_W'(nz);
                state_next = ST_G2;
            end
            ST_G2:
            begin
                big_next    = (grid > 40'(MAX_CELLS));
                active_next = big_next ? CNT_W'(MAX_CELLS) : grid[CNT_W-1:0];
                cnt_next    = '0;
                run_next    = '0;
                case (req_reg.opcode)
                    OP_CLEAR:
                    begin
                        state_next = ST_CLR;
                    end
                    OP_INSERT:
                    begin
                        mul_a      = MUL_A_W'(req_reg.pos_x);
                        mul_b      = cfg.scale_x;
                        state_next = ST_IX;
                    end
                    OP_BUILD:
                    begin
                        state_next = ST_BRD;
                    end
                    OP_READ_SLOT:
                    begin
                        so_raddr   = req_reg.slot;
                        state_next = ({1'b0, req_reg.slot} < total_reg) ? ST_RSLOT
                                                                        : ST_DONE;
                    end
                    OP_READ_CELL:
                    begin
                        cc_raddr   = req_reg.cell_req;
                        st_raddr   = req_reg.cell_req;
                        state_next = ({1'b0, req_reg.cell_req} < active_next) ? ST_RCELL
                                                                              : ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_IX:
            begin
                cx_next    = sat[AXIS_W-1:0];
                flag_next  = flag_reg | sat[AXIS_W];
                mul_a      = MUL_A_W'(req_reg.pos_y);
                mul_b      = cfg.scale_y;
                state_next = ST_IY;
            end
            ST_IY:
            begin
                cy_next    = sat[AXIS_W-1:0];
                flag_next  = flag_reg | sat[AXIS_W];
                mul_a      = MUL_A_W'(req_reg.pos_z);
                mul_b      = cfg.scale_z;
                state_next = ST_IZ;
            end
            ST_IZ:
            begin
                cz_next    = sat[AXIS_W-1:0];
                flag_next  = flag_reg | sat[AXIS_W];
                mul_a      = MUL_A_W'(cx_reg);
                mul_b      = MUL_B_W'(ny);
                state_next = ST_IL0;
            end
            ST_IL0:
            begin
                mul_a      = tsum;
                mul_b      = MUL_B_W'(nz);
                state_next = ST_IL1;
            end
            ST_IL1:
            begin
                lin_next = (lin_full >= 41'(MAX_CELLS)) ? CELL_W'(MAX_CELLS - 1)
                                                        : lin_full[CELL_W-1:0];
                res_next.cell_of_item = lin_next;
                res_next.out_of_range = flag_reg | big_reg;
                if (total_reg < CNT_W'(MAX_PARTICLES))
                begin
                    pc_we      = 1'b1;
                    pc_waddr   = req_reg.particle_id;
                    pc_wdata   = lin_next;
                    cc_raddr   = lin_next;
                    state_next = ST_ICNT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ICNT:
            begin
                cc_we      = 1'b1;
                cc_waddr   = lin_reg;
                cc_wdata   = cc_rd + 1'b1;
                total_next = total_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_BRD:
            begin
                cc_raddr = cnt_reg[CELL_W-1:0];
                if (cnt_reg < active_reg)
                begin
                    state_next = ST_BWR;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_PRD;
                end
            end
            ST_BWR:
            begin
                st_we      = 1'b1;
                st_waddr   = cnt_reg[CELL_W-1:0];
                st_wdata   = run_reg;
                cc_we      = 1'b1;
                cc_waddr   = cnt_reg[CELL_W-1:0];
                run_next   = run_reg + cc_rd;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_BRD;
            end
            ST_PRD:
            begin
                pc_raddr   = cnt_reg[ID_W-1:0];
                state_next = (cnt_reg < total_reg) ? ST_PCI : ST_DONE;
            end
            ST_PCI:
            begin
                ci_next  = pc_rd;
                cc_raddr = pc_rd;
                st_raddr = pc_rd;
                if ({1'b0, pc_rd} >= active_reg)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_PRD;
                end
                else
                begin
                    state_next = ST_PSC;
                end
            end
            ST_PSC:
            begin
                cc_we    = 1'b1;
                cc_waddr = ci_reg;
                cc_wdata = cc_rd + 1'b1;
                if (at < (CNT_W+1)'(MAX_PARTICLES))
                begin
                    so_we    = 1'b1;
                    so_waddr = at[ID_W-1:0];
                    so_wdata = cnt_reg[ID_W-1:0];
                end
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_PRD;
            end
            ST_RSLOT:
            begin
                res_next.sorted_id = so_rd;
                state_next         = ST_DONE;
            end
            ST_RCELL:
            begin
                res_next.cell_start = st_rd;
                res_next.cell_count = cc_rd;
                state_next          = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res             = res_reg;
        res.total_count = total_reg;
    end

endmodule

// ----- rtl/cell_list_counting_sort.sv -----
// One request at a time: the next is accepted in the cycle after the core hands its
// result to the output register, where it may still wait.
// Reset: asynchronous, active low; then a pass over all 4096 cells zeroes the per-cell
// counts, during which no request is accepted (configuration writes are taken).
module cell_list_counting_sort (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [clsort_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clsort_pkg::SCALE_W-1:0]        cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // particle_id, pos_x, pos_y, pos_z, slot, cell_req, zero fill
    input  logic [87:0]                           s_tdata,
    // opcode
    input  logic [2:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // sorted_id, cell_of_item, cell_start, cell_count, total_count, zero fill
    output logic [63:0]                           m_tdata,
    // out_of_range
    output logic [0:0]                            m_tuser
);
    import clsort_pkg::*;

    cfg_t  cfg_reg;
    req_t  req;
    res_t  res, out_reg;
    logic  out_valid_reg;
    logic  res_valid, res_ready, req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cells_x <= AXIS_W'(1);
            cfg_reg.cells_y <= AXIS_W'(1);
            cfg_reg.cells_z <= AXIS_W'(1);
            cfg_reg.scale_x <= '0;
            cfg_reg.scale_y <= '0;
            cfg_reg.scale_z <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELLS_X: cfg_reg.cells_x <= cfg_data[AXIS_W-1:0];
                REG_CELLS_Y: cfg_reg.cells_y <= cfg_data[AXIS_W-1:0];
                REG_CELLS_Z: cfg_reg.cells_z <= cfg_data[AXIS_W-1:0];
                REG_SCALE_X: cfg_reg.scale_x <= cfg_data;
                REG_SCALE_Y: cfg_reg.scale_y <= cfg_data;
                REG_SCALE_Z: cfg_reg.scale_z <= cfg_data;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    assign req.opcode      = s_tuser;
    assign req.particle_id = s_tdata[11:0];
    assign req.pos_x       = s_tdata[27:12];
    assign req.pos_y       = s_tdata[43:28];
    assign req.pos_z       = s_tdata[59:44];
    assign req.slot        = s_tdata[71:60];
    assign req.cell_req    = s_tdata[83:72];

    assign res_ready = !out_valid_reg || m_tready;
    assign s_tready  = req_ready;

    clsort_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (s_tvalid),
        .req       (req),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.total_count, out_reg.cell_count, out_reg.cell_start,
                       out_reg.cell_of_item, out_reg.sorted_id};
    assign m_tuser  = out_reg.out_of_range;

endmodule

// ----- test/cell_list_counting_sort_check.sv -----
`timescale 1ns / 1ps
// Checker for cell_list_counting_sort: watches the configuration port and both
// streams, predicts every result from its own copy of the grid state, compares.
// Depends on clsort_pkg for field widths and operation codes.
module cell_list_counting_sort_check
    import clsort_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SCALE_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [87:0]          s_tdata,
    input  logic [2:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [63:0]          m_tdata,
    input  logic [0:0]           m_tuser,
    output int                   errors,
    output int                   pending,
    output int                   results_seen
);

    logic [AXIS_W-1:0]  grid_x, grid_y, grid_z;
    logic [SCALE_W-1:0] inv_x, inv_y, inv_z;
    int unsigned        id_cell [MAX_PARTICLES];
    int unsigned        bin_count [MAX_CELLS];
    int unsigned        bin_start [MAX_CELLS];
    int unsigned        order_ids [MAX_PARTICLES];
    int unsigned        stored_total;
    res_t               awaited [$];

    function automatic longint unsigned axis_n(logic [AXIS_W-1:0] r);
        return (r == 0) ? 1 : longint'(r);
    endfunction

    function automatic longint unsigned grid_cells();
        return axis_n(grid_x) * axis_n(grid_y) * axis_n(grid_z);
    endfunction

    function automatic longint unsigned live_cells();
        longint unsigned p;
        p = grid_cells();
        return (p > MAX_CELLS) ? MAX_CELLS : p;
    endfunction

    function automatic longint unsigned bin_axis(logic [COORD_W-1:0] pos,
            logic [SCALE_W-1:0] sc, longint unsigned n, ref bit oor);
        longint unsigned c;
        c = (longint'(pos) * longint'(sc)) >> 16;
        if (c == n)
            c = n - 1;
        else if (c > n)
        begin
            c = n - 1;
            oor = 1;
        end
        return c;
    endfunction

    function void sort_bins();
        longint unsigned nc;
        int unsigned     run;
        int unsigned     ci;
        int unsigned     at;
        nc = live_cells();
        run = 0;
        for (int c = 0; c < nc; c++)
        begin
            bin_start[c] = run;
            run += bin_count[c];
            bin_count[c] = 0;
        end
        for (int i = 0; i < stored_total && i < MAX_PARTICLES; i++)
        begin
            ci = id_cell[i];
            if (ci < nc)
            begin
                at = bin_start[ci] + bin_count[ci];
                bin_count[ci]++;
                if (at < MAX_PARTICLES)
                    order_ids[at] = i;
            end
        end
    endfunction

    function res_t predict_result(req_t rq);
        res_t            r;
        bit              oor;
        longint unsigned nx, ny, nz, cx, cy, cz, lin;
        r = '0;
        oor = 0;
        case (rq.opcode)
            OP_CLEAR:
            begin
                foreach (bin_count[c])
                    bin_count[c] = 0;
                stored_total = 0;
            end
            OP_INSERT:
            begin
                nx = axis_n(grid_x);
                ny = axis_n(grid_y);
                nz = axis_n(grid_z);
                cx = bin_axis(rq.pos_x, inv_x, nx, oor);
                cy = bin_axis(rq.pos_y, inv_y, ny, oor);
                cz = bin_axis(rq.pos_z, inv_z, nz, oor);
                lin = (cx * ny + cy) * nz + cz;
                if (grid_cells() > MAX_CELLS)
                    oor = 1;
                if (lin >= MAX_CELLS)
                    lin = MAX_CELLS - 1;
                if (stored_total < MAX_PARTICLES)
                begin
                    id_cell[rq.particle_id] = lin;
                    bin_count[lin]++;
                    stored_total++;
                end
                r.cell_of_item = lin[CELL_W-1:0];
                r.out_of_range = oor;
            end
            OP_BUILD:
                sort_bins();
            OP_READ_SLOT:
                if (rq.slot < stored_total)
                    r.sorted_id = order_ids[rq.slot][ID_W-1:0];
            OP_READ_CELL:
                if (rq.cell_req < live_cells())
                begin
                    r.cell_start = bin_start[rq.cell_req][CNT_W-1:0];
                    r.cell_count = bin_count[rq.cell_req][CNT_W-1:0];
                end
            default: ;
        endcase
        r.total_count = stored_total[CNT_W-1:0];
        return r;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        req_t rq;
        res_t want;
        if (!rst_n)
        begin
            grid_x <= 1;
            grid_y <= 1;
            grid_z <= 1;
            inv_x <= 0;
            inv_y <= 0;
            inv_z <= 0;
            stored_total = 0;
            foreach (bin_count[c])
                bin_count[c] = 0;
            awaited.delete();
            errors <= 0;
            pending <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (awaited.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    check_field("sorted_id", want.sorted_id, m_tdata[11:0]);
                    check_field("cell_of_item", want.cell_of_item, m_tdata[23:12]);
                    check_field("cell_start", want.cell_start, m_tdata[36:24]);
                    check_field("cell_count", want.cell_count, m_tdata[49:37]);
                    check_field("total_count", want.total_count, m_tdata[62:50]);
                    check_field("out_of_range", want.out_of_range, m_tuser[0]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                rq.opcode      = s_tuser;
                rq.particle_id = s_tdata[11:0];
                rq.pos_x       = s_tdata[27:12];
                rq.pos_y       = s_tdata[43:28];
                rq.pos_z       = s_tdata[59:44];
                rq.slot        = s_tdata[71:60];
                rq.cell_req    = s_tdata[83:72];
                awaited.push_back(predict_result(rq));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CELLS_X: grid_x <= cfg_data[AXIS_W-1:0];
                    REG_CELLS_Y: grid_y <= cfg_data[AXIS_W-1:0];
                    REG_CELLS_Z: grid_z <= cfg_data[AXIS_W-1:0];
                    REG_SCALE_X: inv_x <= cfg_data;
                    REG_SCALE_Y: inv_y <= cfg_data;
                    REG_SCALE_Z: inv_z <= cfg_data;
                    default: ;
                endcase
            end
            pending <= awaited.size();
        end
    end

endmodule

// ----- test/cell_list_counting_sort_test.sv -----
`timescale 1ns / 1ps
// Top of the cell_list_counting_sort test: clock, reset, request stimulus in
// phases of clear, insert, build and read, random stalls, watchdog and verdict.
// Depends on clsort_pkg, the block and cell_list_counting_sort_check.
module cell_list_counting_sort_test;
    import clsort_pkg::*;

    localparam int STALL_LIMIT = 100000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCALE_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [87:0]          s_tdata;
    logic [2:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;
    logic [0:0]           m_tuser;
    int                   errors;
    int                   pending;
    int                   results_seen;
    int                   requests_sent;
    int                   phases_run;
    int                   quiet_cycles;
    int                   hold_left;
    bit                   calm;
    longint unsigned      live;

    cell_list_counting_sort dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    cell_list_counting_sort_check checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            m_tready <= 1;
            hold_left <= 0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if ($urandom_range(0, 3) == 0)
        begin
            m_tready <= 0;
            hold_left <= $urandom_range(0, 15);
        end
        else
        begin
            m_tready <= 1;
            hold_left <= $urandom_range(0, 15);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("cell_list_counting_sort_test: errors");
            $finish;
        end
    end

    task automatic send(input logic [OP_W-1:0] op, input int unsigned id,
            input int unsigned px, input int unsigned py, input int unsigned pz,
            input int unsigned sl, input int unsigned cr);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {4'b0, cr[11:0], sl[11:0], pz[15:0], py[15:0], px[15:0], id[11:0]};
        do @(posedge clk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_grid(input int unsigned nx, input int unsigned ny, input int unsigned nz,
            input int unsigned sx, input int unsigned sy, input int unsigned sz);
        int unsigned vals [6];
        logic [CFG_IDX_W-1:0] idx [6];
        vals = '{nx, ny, nz, sx, sy, sz};
        idx = '{REG_CELLS_X, REG_CELLS_Y, REG_CELLS_Z, REG_SCALE_X, REG_SCALE_Y, REG_SCALE_Z};
        settle();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we <= 1;
            cfg_index <= idx[i];
            cfg_data <= vals[i][SCALE_W-1:0];
            @(posedge clk);
        end
        cfg_we <= 0;
        live = ((nx == 0) ? 1 : nx) * ((ny == 0) ? 1 : ny) * ((nz == 0) ? 1 : nz);
        if (live > MAX_CELLS)
            live = MAX_CELLS;
    endtask

    function automatic int unsigned coord();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 16'hFFFF;
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    task automatic insert_ids(input int first, input int last);
        int ids [$];
        int j, t;
        for (int i = first; i < last; i++)
            ids.push_back(i);
        for (int i = ids.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = ids[i];
            ids[i] = ids[j];
            ids[j] = t;
        end
        foreach (ids[i])
            send(OP_INSERT, ids[i], coord(), coord(), coord(),
                 $urandom_range(0, 4095), $urandom_range(0, 4095));
    endtask

    task automatic read_back(input int n, input int total);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send(OP_READ_SLOT, $urandom, $urandom, $urandom, $urandom,
                                 $urandom_range(0, total - 1), $urandom);
                4: send(OP_READ_SLOT, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(0, 4095), $urandom);
                5, 6, 7: send(OP_READ_CELL, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom_range(0, live - 1));
                8: send(OP_READ_CELL, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom_range(0, 4095));
                default:
                    if ($urandom_range(0, 1))
                        send(OP_BUILD, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
                    else
                        send($urandom_range(5, 7), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
            endcase
        end
    endtask

    // clear, insert a permutation, build, read; optionally a second batch and overflow
    task automatic run_phase(input int n1, input int n2, input int reads, input bit overflow);
        send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        insert_ids(0, n1);
        send(OP_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        read_back(reads, n1);
        if (n2 > n1)
        begin
            insert_ids(n1, n2);
            send(OP_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            read_back(reads, n2);
        end
        if (overflow)
        begin
            send(OP_INSERT, $urandom_range(0, 4095), coord(), coord(), coord(), 0, 0);
            send(OP_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            read_back(reads, n2);
        end
        phases_run++;
    endtask

    initial
    begin
        int unsigned nx, ny, nz;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        calm = 0;
        requests_sent = 0;
        phases_run = 0;
        live = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // x lands exactly on the count, z saturates
        set_grid(4, 4, 4, 5, 4, 8);
        send(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        send(OP_INSERT, 0, 0, 0, 0, 0, 0);
        send(OP_INSERT, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0);
        send(OP_INSERT, 2, 16'hFFFF, 0, 0, 0, 0);
        send(OP_INSERT, 3, 0, 0, 16'hFFFF, 0, 0);
        send(OP_BUILD, 0, 0, 0, 0, 0, 0);
        send(OP_READ_SLOT, 0, 0, 0, 0, 0, 0);
        send(OP_READ_SLOT, 0, 0, 0, 0, 3, 0);
        send(OP_READ_SLOT, 0, 0, 0, 0, 4095, 0);
        send(OP_READ_CELL, 0, 0, 0, 0, 0, 63);
        send(OP_READ_CELL, 0, 0, 0, 0, 0, 64);
        send(OP_READ_CELL, 0, 0, 0, 0, 0, 4095);
        send(3'd5, 4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4095, 4095);
        send(3'd6, 0, 0, 0, 0, 0, 0);
        send(3'd7, 0, 0, 0, 0, 0, 0);
        phases_run++;

        set_grid(0, 3, 0, 0, 3, 0);
        run_phase(10, 20, 12, 0);
        set_grid(16, 16, 16, 16, 17, 40);
        run_phase(25, 40, 15, 0);
        set_grid(4096, 1, 1, 4096, 1048575, 0);
        run_phase(20, 20, 15, 0);
        set_grid(1, 1, 4096, 0, 0, 4096);
        run_phase(15, 15, 10, 0);
        set_grid(4096, 4096, 1, 1048575, 1048575, 1048575);
        run_phase(15, 15, 10, 0);
        set_grid(8, 8, 8, 8, 8, 9);
        run_phase(24, 24, 15, 0);
        for (int p = 0; p < 4; p++)
        begin
            nx = $urandom_range(1, 16);
            ny = $urandom_range(1, 16);
            nz = $urandom_range(1, 16);
            set_grid(nx, ny, nz, $urandom_range(nx / 2, 2 * nx + 1),
                     $urandom_range(ny / 2, 2 * ny + 1), $urandom_range(0, 2 * nz + 1));
            run_phase($urandom_range(5, 12), $urandom_range(12, 20), 6, 0);
        end
        set_grid(3, 5, 7, 4, 5, 8);
        calm = 1;
        run_phase(15, 15, 20, 0);

        settle();
        $display("%0d requests over %0d grid settings, %0d results checked",
                 requests_sent, phases_run, results_seen);
        if (errors == 0 && pending == 0)
            $display("cell_list_counting_sort_test: clean");
        else
            $display("cell_list_counting_sort_test: errors");
        $finish;
    end

endmodule

// ----- cell_list_counting_sort.f -----
rtl/clsort_pkg.sv
rtl/clsort_mul.sv
rtl/clsort_core.sv
rtl/cell_list_counting_sort.sv
test/cell_list_counting_sort_check.sv
test/cell_list_counting_sort_test.sv
